[src/lcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants of the lba to chs transfer splitter
// Widths of the block address, geometry registers, divider interface types
// and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int ADDR_BITS     = 24;
   localparam int MAX_REQ       = 64;
   localparam int COUNT_BITS    = 7;
   localparam int SPT_BITS      = 6;
   localparam int HEAD_BITS     = 9;
   localparam int BUF_BITS      = 8;
   localparam int CSR_DATA_BITS = 9;
   localparam int CSR_IDX_BITS  = 2;
   localparam int DIV_CNT_BITS  = $clog2(ADDR_BITS);

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPT   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEADS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BUF   = 2'd2;

   localparam logic [SPT_BITS-1:0]  SPT_RESET   = 6'd18;
   localparam logic [HEAD_BITS-1:0] HEADS_RESET = 9'd2;
   localparam logic [BUF_BITS-1:0]  BUF_RESET   = 8'd32;
   localparam logic [HEAD_BITS-1:0] HEADS_MAX   = 9'd256;

   localparam logic [1:0] FN_READ  = 2'd2;
   localparam logic [1:0] FN_WRITE = 2'd3;

   typedef struct packed {
      logic                 start;
      logic [ADDR_BITS-1:0] dividend;
      logic [HEAD_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [ADDR_BITS-1:0] quotient;
      logic [HEAD_BITS-1:0] remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_DIV_SPT  = 4'b0010,
      ST_DIV_HEAD = 4'b0100,
      ST_EMIT     = 4'b1000
   } state_type;

endpackage
`default_nettype wire

[src/lcs_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_divider: shared restoring divider
// Divides the block address width dividend by a 9 bit divisor, one quotient
// bit per cycle; done pulses when quotient and remainder are final.
// ----------------------------------------------------------------------------
module lcs_divider (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lcs_pkg::div_req_type div_req,
   output      lcs_pkg::div_rsp_type div_rsp
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [lcs_pkg::DIV_CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [lcs_pkg::ADDR_BITS-1:0]        quo_ff, quo_in;
   logic [lcs_pkg::HEAD_BITS-1:0]        rem_ff, rem_in;
   logic [lcs_pkg::HEAD_BITS-1:0]        div_ff, div_in;
   logic [lcs_pkg::HEAD_BITS:0]          shifted;
   logic [lcs_pkg::HEAD_BITS:0]          diff;

   assign shifted = {rem_ff, quo_ff[lcs_pkg::ADDR_BITS-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[lcs_pkg::HEAD_BITS-1:0];
            quo_in = {quo_ff[lcs_pkg::ADDR_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[lcs_pkg::HEAD_BITS-1:0];
            quo_in = {quo_ff[lcs_pkg::ADDR_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lcs_pkg::DIV_CNT_BITS'(lcs_pkg::ADDR_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

[src/lba_to_chs_transfer_splitter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lba_to_chs_transfer_splitter: splits a disk transfer into int 13h chunks
// A request (direction, start block, block count) enters on req_valid while
// req_stall is low; req_stall stays high until the last chunk has been loaded
// into the output register. Each chunk leaves on the rsp_ channel, one per
// rsp_valid cycle that rsp_stall is low; a stalled response holds steady and
// the sequencer waits on it.
// One shared restoring divider of 24 iterations runs twice, block by sectors
// per track and then track by heads, before the first chunk is loaded into
// the output register. Later chunks follow one per cycle while rsp_stall is
// low, by stepping sector, head and cylinder, except that a block address
// wrapping past the top reruns both divisions.
// A zero block count gives no response and never raises req_stall.
// Geometry registers are written through csr_ while the block is idle; the
// user must keep to this, as the block itself does not enforce it.
// Reset (synchronous) restores 18 sectors, 2 heads, 32 buffer blocks and
// drops any request in flight.
// ----------------------------------------------------------------------------
module lba_to_chs_transfer_splitter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [lcs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [lcs_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_func,
   input  wire logic [lcs_pkg::ADDR_BITS-1:0]     req_start_block,
   input  wire logic [lcs_pkg::COUNT_BITS-1:0]    req_block_count,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic [9:0]                        rsp_cylinder,
   output      logic [7:0]                        rsp_head_number,
   output      logic [5:0]                        rsp_sector_number,
   output      logic [6:0]                        rsp_chunk_count,
   output      logic [7:0]                        rsp_ch_byte,
   output      logic [7:0]                        rsp_cl_byte,
   output      logic [1:0]                        rsp_bios_function,
   output      logic                              rsp_cylinder_overflow,
   output      logic                              rsp_last_chunk
);

   localparam int AB = lcs_pkg::ADDR_BITS;
   localparam int CB = lcs_pkg::COUNT_BITS;
   localparam int SB = lcs_pkg::SPT_BITS;
   localparam int HB = lcs_pkg::HEAD_BITS;

   // geometry registers
   logic [SB-1:0]                 spt_ff;
   logic [HB-1:0]                 heads_ff;
   logic [lcs_pkg::BUF_BITS-1:0]  buf_ff;
   logic [SB-1:0]                 spt_eff;
   logic [HB-1:0]                 heads_eff;
   logic [lcs_pkg::BUF_BITS-1:0]  buf_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= lcs_pkg::SPT_RESET;
         heads_ff <= lcs_pkg::HEADS_RESET;
         buf_ff   <= lcs_pkg::BUF_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lcs_pkg::CSR_SPT:   spt_ff   <= csr_wdata[SB-1:0];
            lcs_pkg::CSR_HEADS: heads_ff <= csr_wdata[HB-1:0];
            lcs_pkg::CSR_BUF:   buf_ff   <= csr_wdata[lcs_pkg::BUF_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      spt_eff = (spt_ff == '0) ? SB'(1) : spt_ff;
      buf_eff = (buf_ff == '0) ? lcs_pkg::BUF_BITS'(1) : buf_ff;
      if (heads_ff == '0) begin
         heads_eff = HB'(1);
      end else if (heads_ff > lcs_pkg::HEADS_MAX) begin
         heads_eff = lcs_pkg::HEADS_MAX;
      end else begin
         heads_eff = heads_ff;
      end
   end

   // shared divider
   lcs_pkg::div_req_type div_req;
   lcs_pkg::div_rsp_type div_rsp;

   lcs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // sequencer and position state
   lcs_pkg::state_type state_ff, state_in;
   logic          func_ff, func_in;
   logic [AB-1:0] block_ff, block_in;
   logic [CB-1:0] remain_ff, remain_in;
   logic [SB-1:0] sec0_ff, sec0_in;
   logic [HB-1:0] head_ff, head_in;
   logic [AB-1:0] cyl_ff, cyl_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [9:0] out_cyl_ff, out_cyl_in;
   logic [7:0] out_head_ff, out_head_in;
   logic [5:0] out_sec_ff, out_sec_in;
   logic [6:0] out_cnt_ff, out_cnt_in;
   logic       out_fn_ff, out_fn_in;
   logic       out_ovf_ff, out_ovf_in;
   logic       out_last_ff, out_last_in;

   logic          req_accept;
   logic          slot_free;
   logic [CB-1:0] req_count_sat;
   logic [CB-1:0] avail;
   logic [CB-1:0] chunk;
   logic [CB-1:0] remain_next;
   logic [AB:0]   block_sum;
   logic [HB-1:0] head_inc;

   assign req_stall  = (state_ff != lcs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !out_valid_ff || !rsp_stall;

   always_comb begin
      if (req_block_count > CB'(lcs_pkg::MAX_REQ)) begin
         req_count_sat = CB'(lcs_pkg::MAX_REQ);
      end else begin
         req_count_sat = req_block_count;
      end
   end

   // chunk length: min of track rest, blocks left and buffer size
   always_comb begin
      avail = {1'b0, spt_eff} - {1'b0, sec0_ff};
      chunk = avail;
      if (remain_ff < chunk) begin
         chunk = remain_ff;
      end
      if (buf_eff < {1'b0, chunk}) begin
         chunk = buf_eff[CB-1:0];
      end
      remain_next = remain_ff - chunk;
      block_sum   = {1'b0, block_ff} + {{(AB+1-CB){1'b0}}, chunk};
      head_inc    = head_ff + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      block_in     = block_ff;
      remain_in    = remain_ff;
      sec0_in      = sec0_ff;
      head_in      = head_ff;
      cyl_in       = cyl_ff;
      div_req      = '0;
      out_valid_in = out_valid_ff && rsp_stall;
      out_cyl_in   = out_cyl_ff;
      out_head_in  = out_head_ff;
      out_sec_in   = out_sec_ff;
      out_cnt_in   = out_cnt_ff;
      out_fn_in    = out_fn_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         lcs_pkg::ST_IDLE: begin
            if (req_accept) begin
               func_in   = req_func;
               block_in  = req_start_block;
               remain_in = req_count_sat;
               if (req_count_sat != '0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = req_start_block;
                  div_req.divisor  = {{(HB-SB){1'b0}}, spt_eff};
                  state_in         = lcs_pkg::ST_DIV_SPT;
               end
            end
         end
         lcs_pkg::ST_DIV_SPT: begin
            if (div_rsp.done) begin
               sec0_in          = div_rsp.remainder[SB-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = heads_eff;
               state_in         = lcs_pkg::ST_DIV_HEAD;
            end
         end
         lcs_pkg::ST_DIV_HEAD: begin
            if (div_rsp.done) begin
               cyl_in   = div_rsp.quotient;
               head_in  = div_rsp.remainder;
               state_in = lcs_pkg::ST_EMIT;
            end
         end
         lcs_pkg::ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_cyl_in   = cyl_ff[9:0];
               out_head_in  = head_ff[7:0];
               out_sec_in   = sec0_ff + 1'b1;
               out_cnt_in   = chunk;
               out_fn_in    = func_ff;
               out_ovf_in   = (cyl_ff[AB-1:10] != '0);
               out_last_in  = (remain_next == '0);
               remain_in    = remain_next;
               block_in     = block_sum[AB-1:0];
               if (chunk == avail) begin
                  sec0_in = '0;
                  if (head_inc == heads_eff) begin
                     head_in = '0;
                     cyl_in  = cyl_ff + 1'b1;
                  end else begin
                     head_in = head_inc;
                  end
               end else begin
                  sec0_in = sec0_ff + chunk[SB-1:0];
               end
               if (remain_next == '0) begin
                  state_in = lcs_pkg::ST_IDLE;
               end else if (block_sum[AB]) begin
                  // address wrapped past the top: locate it again
                  div_req.start    = 1'b1;
                  div_req.dividend = block_sum[AB-1:0];
                  div_req.divisor  = {{(HB-SB){1'b0}}, spt_eff};
                  state_in         = lcs_pkg::ST_DIV_SPT;
               end
            end
         end
         default: begin
            state_in = lcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcs_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      func_ff     <= func_in;
      block_ff    <= block_in;
      remain_ff   <= remain_in;
      sec0_ff     <= sec0_in;
      head_ff     <= head_in;
      cyl_ff      <= cyl_in;
      out_cyl_ff  <= out_cyl_in;
      out_head_ff <= out_head_in;
      out_sec_ff  <= out_sec_in;
      out_cnt_ff  <= out_cnt_in;
      out_fn_ff   <= out_fn_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_cylinder          = out_cyl_ff;
   assign rsp_head_number       = out_head_ff;
   assign rsp_sector_number     = out_sec_ff;
   assign rsp_chunk_count       = out_cnt_ff;
   assign rsp_ch_byte           = out_cyl_ff[7:0];
   assign rsp_cl_byte           = {out_cyl_ff[9:8], out_sec_ff};
   assign rsp_bios_function     = out_fn_ff ? lcs_pkg::FN_WRITE : lcs_pkg::FN_READ;
   assign rsp_cylinder_overflow = out_ovf_ff;
   assign rsp_last_chunk        = out_last_ff;

endmodule
`default_nettype wire
